>>> rtl/lmn_pkg.sv
// Shared codes for the Lamport mutual exclusion node.
package lmn_pkg;

  // Item operations (s_tuser[1:0])
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_DONE    = 2'd2;
  localparam logic [1:0] OP_MESSAGE = 2'd3;

  // Received message types (s_tuser[4:2])
  localparam logic [2:0] MSG_REQUEST = 3'd0;
  localparam logic [2:0] MSG_REPLY   = 3'd1;
  localparam logic [2:0] MSG_RELEASE = 3'd2;
  localparam logic [2:0] MSG_DONE    = 3'd3;

  // Outgoing send kinds and types
  localparam logic [1:0] SEND_NONE      = 2'd0;
  localparam logic [1:0] SEND_BROADCAST = 2'd1;
  localparam logic [1:0] SEND_UNICAST   = 2'd2;

  localparam logic [1:0] STYPE_REQUEST = 2'd0;
  localparam logic [1:0] STYPE_REPLY   = 2'd1;
  localparam logic [1:0] STYPE_RELEASE = 2'd2;
  localparam logic [1:0] STYPE_DONE    = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] REG_NODE_COUNT = 1'd0;
  localparam logic [0:0] REG_OWN_ID     = 1'd1;

  localparam logic [4:0] NODE_COUNT_RESET = 5'd16;
  localparam logic [3:0] OWN_ID_RESET     = 4'd1;
  localparam logic [4:0] REPLY_COUNT_MAX  = 5'd31;

  typedef logic [2:0] seq_state_t;

endpackage

>>> rtl/lamport_mutex_node_top.sv
// Lamport mutual exclusion node: clock, request table and grant sequencer.
//
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+------------------------------------------
// s_*     | in  | s_tvalid / s_tready  | tuser: operation, msg_type
//         |     |                      | tdata: sender_id, msg_time
// m_*     | out | m_tvalid / m_tready  | tuser: send_kind, send_type
//         |     |                      | tdata: send_time, granted, waiting,
//         |     |                      |        all_done, clock_now
// cfg_*   | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// One request runs from accept to result through these steps, with
// N = min(node_count, MAX_NODES):
// a clock tick, a table update, scan reads of stamp memory entries 1 to N-1
// plus a drain step, and a finish. The scan uses one read port and one
// shared comparator.
// rst is synchronous, active high; it clears the clock, flags, counters and
// config to their defaults. The stamp memory is not cleared: a stamp is only
// used when its pending flag is set, and setting that flag writes the stamp.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register; the next request may be accepted meanwhile, and its
// finish step stalls until the output register is free.
module lamport_mutex_node_top #(
  parameter int MAX_NODES  = 16,
  parameter int STAMP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] sender_id, [19:4] msg_time, [23:20] zero
  input  logic [7:0]  s_tuser,   // [1:0] operation, [4:2] msg_type, [7:5] zero
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] send_time, [16] granted, [17] waiting,
                                 // [18] all_done, [34:19] clock_now, [39:35] zero
  output logic [7:0]  m_tuser,   // [1:0] send_kind, [3:2] send_type, [7:4] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import lmn_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

  localparam seq_state_t S_IDLE = 3'd0;
  localparam seq_state_t S_TICK = 3'd1;
  localparam seq_state_t S_UPD  = 3'd2;
  localparam seq_state_t S_SCAN = 3'd3;
  localparam seq_state_t S_FIN  = 3'd4;

  seq_state_t state;

  // config
  logic [4:0] node_count;
  logic [3:0] own_id;

  // node state
  logic [STAMP_BITS-1:0] lamport_clock;
  logic [MAX_NODES-1:0]  pending_flag;
  logic [MAX_NODES-1:0]  done_flag;
  logic [4:0]            reply_count;
  logic                  awaiting_grant;

  // latched request
  logic [1:0]            op;
  logic [2:0]            mtype;
  logic [3:0]            sender;
  logic [STAMP_BITS-1:0] mtime;
  logic                  do_check;
  logic [1:0]            kind;
  logic [1:0]            stype;

  // stamp memory
  logic [STAMP_BITS-1:0] stamp_mem [MAX_NODES];
  logic                  mem_we;
  logic [IW-1:0]         mem_wa;
  logic [STAMP_BITS-1:0] mem_wd;
  logic [IW-1:0]         mem_ra;
  logic [STAMP_BITS-1:0] mem_rdata;

  // scan
  logic [CW-1:0]         idx;
  logic                  sv;
  logic [IW-1:0]         sidx;
  logic                  best_found;
  logic [IW-1:0]         best;
  logic [STAMP_BITS-1:0] best_stamp;
  logic                  alld;
  logic [CW-1:0]         n_act;

  // shared compare / tick unit
  logic [STAMP_BITS-1:0] cmp_a, cmp_b, tick_m, tick_val;
  logic                  cmp_lt;

  logic own_ok, snd_ok, take, grant, out_free;

  // output register
  logic [1:0]  o_kind, o_stype;
  logic [15:0] o_stime, o_clock;
  logic        o_grant, o_wait, o_alld;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign own_ok = 32'(own_id) < MAX_NODES;
  assign snd_ok = 32'(sender) < MAX_NODES;
  assign n_act  = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);

  always_comb begin
    if (state == S_SCAN) begin
      cmp_a = mem_rdata;
      cmp_b = best_stamp;
    end else begin
      cmp_a = lamport_clock;
      cmp_b = (state == S_TICK && op == OP_MESSAGE) ? mtime : '0;
    end
    cmp_lt   = cmp_a < cmp_b;
    tick_m   = cmp_lt ? cmp_b : cmp_a;
    tick_val = (tick_m == STAMP_MAX) ? STAMP_MAX : tick_m + 1'b1;
  end

  assign take = sv && pending_flag[sidx] && (!best_found || cmp_lt);

  always_comb begin
    grant = do_check && (n_act >= CW'(2)) && (own_id != 4'd0) &&
            (32'(own_id) < 32'(n_act)) &&
            (32'(reply_count) == 32'(n_act) - 32'd2) &&
            best_found && (32'(best) == 32'(own_id));
  end

  // table write port, driven in the update step
  always_comb begin
    mem_we = 1'b0;
    mem_wa = IW'(own_id);
    mem_wd = lamport_clock;
    if (state == S_UPD) begin
      if (op == OP_REQUEST && own_ok) begin
        mem_we = 1'b1;
      end else if (op == OP_MESSAGE && mtype == MSG_REQUEST && snd_ok) begin
        mem_we = 1'b1;
        mem_wa = IW'(sender);
        mem_wd = mtime;
      end
    end
  end

  assign mem_ra = idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_wa] <= mem_wd;
    end
    mem_rdata <= stamp_mem[mem_ra];
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      own_id     <= OWN_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count <= cfg_data;
        REG_OWN_ID:     own_id     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // scan datapath (payload)
  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      best_found <= 1'b0;
      best       <= '0;
      best_stamp <= '0;
      alld       <= 1'b1;
    end else if (sv) begin
      alld <= alld & done_flag[sidx];
      if (take) begin
        best_found <= 1'b1;
        best       <= sidx;
        best_stamp <= mem_rdata;
      end
    end
    sidx <= idx[IW-1:0];
  end

  // sequencer and node state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      lamport_clock  <= '0;
      pending_flag   <= '0;
      done_flag      <= '0;
      reply_count    <= '0;
      awaiting_grant <= 1'b0;
      m_tvalid       <= 1'b0;
      sv             <= 1'b0;
      idx            <= '0;
      do_check       <= 1'b0;
    end else begin
      // a new result loads the output register; otherwise a taken one empties it
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser[1:0];
            mtype  <= s_tuser[4:2];
            sender <= s_tdata[3:0];
            mtime  <= STAMP_BITS'(s_tdata[19:4]);
            state  <= S_TICK;
          end
        end
        S_TICK: begin
          lamport_clock <= tick_val;
          state         <= S_UPD;
        end
        S_UPD: begin
          unique case (op)
            OP_REQUEST: begin
              if (own_ok) pending_flag[IW'(own_id)] <= 1'b1;
              reply_count    <= '0;
              awaiting_grant <= 1'b1;
              kind           <= SEND_BROADCAST;
              stype          <= STYPE_REQUEST;
              do_check       <= 1'b0;
            end
            OP_RELEASE: begin
              if (own_ok) pending_flag[IW'(own_id)] <= 1'b0;
              awaiting_grant <= 1'b0;
              kind           <= SEND_BROADCAST;
              stype          <= STYPE_RELEASE;
              do_check       <= 1'b0;
            end
            OP_DONE: begin
              if (own_ok) done_flag[IW'(own_id)] <= 1'b1;
              kind     <= SEND_BROADCAST;
              stype    <= STYPE_DONE;
              do_check <= 1'b0;
            end
            OP_MESSAGE: begin
              unique case (mtype)
                MSG_REQUEST: begin
                  if (snd_ok) pending_flag[IW'(sender)] <= 1'b1;
                  lamport_clock <= tick_val;   // reply raises the clock again
                  kind          <= SEND_UNICAST;
                  stype         <= STYPE_REPLY;
                  do_check      <= 1'b0;
                end
                MSG_REPLY: begin
                  if (awaiting_grant && reply_count != REPLY_COUNT_MAX) begin
                    reply_count <= reply_count + 5'd1;
                  end
                  kind     <= SEND_NONE;
                  stype    <= STYPE_REQUEST;
                  do_check <= awaiting_grant;
                end
                MSG_RELEASE: begin
                  if (snd_ok) pending_flag[IW'(sender)] <= 1'b0;
                  kind     <= SEND_NONE;
                  stype    <= STYPE_REQUEST;
                  do_check <= awaiting_grant;
                end
                MSG_DONE: begin
                  if (snd_ok) done_flag[IW'(sender)] <= 1'b1;
                  kind     <= SEND_NONE;
                  stype    <= STYPE_REQUEST;
                  do_check <= 1'b0;
                end
                default: begin   // clock update only
                  kind     <= SEND_NONE;
                  stype    <= STYPE_REQUEST;
                  do_check <= 1'b0;
                end
              endcase
            end
            default: begin
              kind     <= SEND_NONE;
              stype    <= STYPE_REQUEST;
              do_check <= 1'b0;
            end
          endcase
          idx   <= CW'(1);
          sv    <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // issue one stamp read per cycle; the compare follows in the next cycle
          if (idx < n_act) begin
            sv  <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            sv    <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            o_kind   <= kind;
            o_stype  <= (kind == SEND_NONE) ? STYPE_REQUEST : stype;
            o_stime  <= (kind == SEND_NONE) ? 16'd0 : 16'(lamport_clock);
            o_grant  <= grant;
            o_wait   <= awaiting_grant && !grant;
            o_alld   <= alld;
            o_clock  <= 16'(lamport_clock);
            if (grant) awaiting_grant <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, o_clock, o_alld, o_wait, o_grant, o_stime};
  assign m_tuser = {4'd0, o_stype, o_kind};

endmodule
